// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the timer core.
// Each macro expects a clock named clk and an active-low reset named rst_n
// in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TMR0_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define TMR0_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/tmr0_pkg.sv =====
`default_nettype none

package tmr0_pkg;

    // Operation carried by each input transaction.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Register map.
    typedef enum logic [1:0] {
        REG_CONTROL    = 2'd0,
        REG_COUNT_LOW  = 2'd1,
        REG_COUNT_HIGH = 2'd2,
        REG_FLAG       = 2'd3
    } reg_sel_t;

    // Control register bit positions.
    localparam int unsigned CTRL_ENABLE_BIT = 7;
    localparam int unsigned CTRL_8BIT_BIT   = 6;
    localparam int unsigned CTRL_BYPASS_BIT = 3;

    localparam logic [7:0] CTRL_RESET = 8'hFF;

    localparam int unsigned PRESCALE_W = 9;

    // One input transaction after unpacking.
    typedef struct packed {
        op_t        op;
        reg_sel_t   reg_select;
        logic [7:0] write_data;
    } tmr0_item_t;

    // One result transaction.
    typedef struct packed {
        logic [7:0] read_data;
        logic       overflow_irq;
    } tmr0_result_t;

    // Prescale ratio for a select code: 2 to 256 in powers of two.
    function automatic logic [PRESCALE_W-1:0] prescale_ratio(input logic [2:0] sel);
        logic [PRESCALE_W-1:0] ratio;
        begin
            ratio = {{(PRESCALE_W-2){1'b0}}, 2'b10} << sel;
            return ratio;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tmr0_in_stage.sv =====
`default_nettype none

module tmr0_in_stage
    import tmr0_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire tmr0_item_t in_item,
    output logic            item_valid,
    output tmr0_item_t      item,
    input  wire logic       item_take
);

    logic       valid_reg;
    logic       valid_next;
    tmr0_item_t item_reg;

    // The stage can load whenever it is empty or its item leaves this cycle.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tmr0_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module tmr0_core
    import tmr0_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire tmr0_item_t item,
    output tmr0_result_t    result
);

    logic [7:0]            control_reg;
    logic [7:0]            count_low_reg;
    logic [7:0]            count_high_reg;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic                  flag_reg;

    logic [7:0]            control_next;
    logic [7:0]            count_low_next;
    logic [7:0]            count_high_next;
    logic [PRESCALE_W-1:0] prescale_next;
    logic                  flag_next;

    logic [PRESCALE_W-1:0] ratio;
    logic [PRESCALE_W-1:0] prescale_inc;
    logic                  prescale_done;
    logic [15:0]           count16_inc;
    logic [7:0]            count8_inc;
    logic                  wrap;

    // Prescale ratio and the tick-driven counter increments.
    assign ratio         = control_reg[CTRL_BYPASS_BIT] ?
                           PRESCALE_W'(1) : prescale_ratio(control_reg[2:0]);
    assign prescale_inc  = prescale_reg + PRESCALE_W'(1);
    assign prescale_done = prescale_inc >= ratio;
    assign count16_inc   = {count_high_reg, count_low_reg} + 16'd1;
    assign count8_inc    = count_low_reg + 8'd1;

    // Next-state and result logic for one transaction.
    always_comb
    begin
        control_next        = control_reg;
        count_low_next      = count_low_reg;
        count_high_next     = count_high_reg;
        prescale_next       = prescale_reg;
        flag_next           = flag_reg;
        wrap                = 1'b0;
        result.read_data    = 8'd0;
        result.overflow_irq = 1'b0;

        unique case (item.op)
            OP_TICK:
            begin
                if (control_reg[CTRL_ENABLE_BIT])
                begin
                    if (!prescale_done)
                    begin
                        prescale_next = prescale_inc;
                    end
                    else
                    begin
                        prescale_next = '0;
                        if (control_reg[CTRL_8BIT_BIT])
                        begin
                            count_low_next = count8_inc;
                            wrap           = (count8_inc == 8'd0);
                        end
                        else
                        begin
                            count_low_next  = count16_inc[7:0];
                            count_high_next = count16_inc[15:8];
                            wrap            = (count16_inc == 16'd0);
                        end
                    end
                end
                if (wrap)
                begin
                    flag_next = 1'b1;
                end
                result.overflow_irq = wrap;
            end
            OP_WRITE:
            begin
                unique case (item.reg_select)
                    REG_CONTROL:    control_next    = item.write_data;
                    REG_COUNT_LOW:  count_low_next  = item.write_data;
                    REG_COUNT_HIGH: count_high_next = item.write_data;
                    REG_FLAG:       flag_next       = item.write_data[0];
                endcase
            end
            OP_READ:
            begin
                unique case (item.reg_select)
                    REG_CONTROL:    result.read_data = control_reg;
                    REG_COUNT_LOW:  result.read_data = count_low_reg;
                    REG_COUNT_HIGH: result.read_data = count_high_reg;
                    REG_FLAG:       result.read_data = {7'd0, flag_reg};
                endcase
            end
            default:
            begin
                // Unused operation code: no state change, zero result.
                wrap = 1'b0;
            end
        endcase
    end

    // Timer state registers, updated only when a transaction is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= CTRL_RESET;
            count_low_reg  <= 8'd0;
            count_high_reg <= 8'd0;
            prescale_reg   <= '0;
            flag_reg       <= 1'b0;
        end
        else if (step)
        begin
            control_reg    <= control_next;
            count_low_reg  <= count_low_next;
            count_high_reg <= count_high_next;
            prescale_reg   <= prescale_next;
            flag_reg       <= flag_next;
        end
    end

    `TMR0_ASSERT(a_irq_only_on_tick, (step && result.overflow_irq) |-> (item.op == OP_TICK),
        "overflow interrupt on a transaction that is not a tick")
    `TMR0_ASSERT(a_irq_sets_flag, (step && result.overflow_irq) |=> flag_reg,
        "overflow interrupt did not set the flag")
    `TMR0_ASSERT(a_idle_holds_count, !step |=> $stable({count_high_reg, count_low_reg}),
        "counter changed without a transaction")
    `TMR0_ASSERT_NEVER(a_prescale_range, prescale_reg[PRESCALE_W-1],
        "prescale counter beyond the largest ratio")

endmodule

`default_nettype wire

// ===== hw/rtl/timer0_prescaled_counter.sv =====
// Timer0-style prescaled 8/16-bit counter behind four byte-wide registers.
// Input channel s_axis_*: one transaction per tick, register write or read;
// tuser carries the operation and register select, tdata the write byte.
// Output channel m_axis_*: exactly one result transaction per input, in
// order; tdata is the read byte (zero unless a read), tuser the overflow
// interrupt pulse for a tick that wrapped the counter to zero.
// Path: an accepted transaction waits in the input register, is processed
// as it moves into the result register, and is then presented with
// m_axis_tvalid.
// Throughput: one transaction per cycle while the output is not stalled;
// the state update between the input and result registers is combinational.
// Reset: control reads 0xFF (enabled, 8-bit mode, prescaler bypassed),
// count, prescale counter and overflow flag are zero, both stages empty.
// Stall: with m_axis_tready low the result holds and the input register
// keeps its transaction, or takes one more if it is empty; s_axis_tready
// is low while both are full and rises in the cycle the result is taken.
`default_nettype none

module timer0_prescaled_counter
    import tmr0_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [7:0] write_data
    input  wire logic [3:0] s_axis_tuser,  // [1:0] op, [3:2] reg_select
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,  // [7:0] read_data
    output logic [0:0]      m_axis_tuser   // [0] overflow_irq
);

    tmr0_item_t   in_item;
    tmr0_item_t   item;
    logic         item_valid;
    logic         step;
    tmr0_result_t result;

    logic         out_valid_reg;
    logic         out_valid_next;
    tmr0_result_t out_reg;

    // Unpack the input transaction.
    assign in_item.op         = op_t'(s_axis_tuser[1:0]);
    assign in_item.reg_select = reg_sel_t'(s_axis_tuser[3:2]);
    assign in_item.write_data = s_axis_tdata;

    tmr0_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (step)
    );

    // Process the held item when the result register is free or draining.
    assign step = item_valid && (!out_valid_reg || m_axis_tready);

    tmr0_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    // Result register.
    assign out_valid_next = step || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg.read_data;
    assign m_axis_tuser[0] = out_reg.overflow_irq;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import tmr0_pkg::*;
;

    // The operation code that the block must treat as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Control register masks used to build settings.
    localparam logic [7:0] CTRL_EN     = 8'h80;
    localparam logic [7:0] CTRL_8BIT   = 8'h40;
    localparam logic [7:0] CTRL_BYPASS = 8'h08;
    localparam logic [7:0] PS_DIV_2    = 8'h00;
    localparam logic [7:0] PS_DIV_256  = 8'h07;

    localparam int unsigned MAX_PRINTED = 50;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] write_data
    logic [3:0] s_axis_tuser;   // [1:0] op, [3:2] reg_select
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] read_data
    logic [0:0] m_axis_tuser;   // [0] overflow_irq

    // Predicted timer state.
    logic [7:0]  tm_ctrl;
    logic [15:0] tm_count;
    logic [8:0]  tm_prescale;
    logic        tm_flag;

    tmr0_result_t pending_results[$];
    int unsigned  mismatch_count;
    int unsigned  items_sent;
    bit           sender_idle;
    bit           receiver_idle;
    int unsigned  long_hold;

    timer0_prescaled_counter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // Applies one transaction to the predicted state and returns its result.
    function automatic tmr0_result_t predict_timer_result(input logic [1:0] op,
                                                          input logic [1:0] sel,
                                                          input logic [7:0] data);
        tmr0_result_t res;
        int unsigned  ratio;
        res = '0;
        case (op)
            OP_TICK:
            begin
                if (tm_ctrl[CTRL_ENABLE_BIT])
                begin
                    ratio = tm_ctrl[CTRL_BYPASS_BIT] ? 1 : (2 << tm_ctrl[2:0]);
                    tm_prescale = tm_prescale + 9'd1;
                    // A lowered ratio takes effect at once since the compare is "at least".
                    if (tm_prescale >= ratio)
                    begin
                        tm_prescale = '0;
                        if (tm_ctrl[CTRL_8BIT_BIT])
                        begin
                            tm_count[7:0] = tm_count[7:0] + 8'd1;
                            res.overflow_irq = (tm_count[7:0] == 8'd0);
                        end
                        else
                        begin
                            tm_count = tm_count + 16'd1;
                            res.overflow_irq = (tm_count == 16'd0);
                        end
                        if (res.overflow_irq)
                            tm_flag = 1'b1;
                    end
                end
            end
            OP_WRITE:
            begin
                case (sel)
                    REG_CONTROL:    tm_ctrl = data;
                    REG_COUNT_LOW:  tm_count[7:0] = data;
                    REG_COUNT_HIGH: tm_count[15:8] = data;
                    default:        tm_flag = data[0];
                endcase
            end
            OP_READ:
            begin
                case (sel)
                    REG_CONTROL:    res.read_data = tm_ctrl;
                    REG_COUNT_LOW:  res.read_data = tm_count[7:0];
                    REG_COUNT_HIGH: res.read_data = tm_count[15:8];
                    default:        res.read_data = {7'd0, tm_flag};
                endcase
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Result checking and prediction of accepted transactions.
    always @(posedge clk)
    begin : result_check
        tmr0_result_t want;
        if (!rst_n)
        begin
            tm_ctrl     = CTRL_RESET;
            tm_count    = '0;
            tm_prescale = '0;
            tm_flag     = 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected", m_axis_tdata, 8'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata !== want.read_data)
                        report_mismatch("read_data", m_axis_tdata, want.read_data);
                    if (m_axis_tuser[0] !== want.overflow_irq)
                        report_mismatch("overflow_irq", {7'd0, m_axis_tuser[0]},
                                        {7'd0, want.overflow_irq});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(predict_timer_result(s_axis_tuser[1:0],
                                                               s_axis_tuser[3:2],
                                                               s_axis_tdata));
        end
    end

    // Result receiver: random stall bursts, plus one long hold on request.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (long_hold) @(negedge clk);
                long_hold = 0;
                m_axis_tready <= 1'b1;
            end
            else if (receiver_idle && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one transaction and returns once it has been accepted.
    task automatic send_item(input logic [1:0] op, input logic [1:0] sel,
                             input logic [7:0] data);
        @(negedge clk);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sel, op};
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Count preload biased toward the top so that wraps happen often.
    function automatic logic [7:0] count_near_top();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'hF8 | 8'($urandom_range(0, 7));
    endfunction

    // A well-formed sequence: set up the timer, then mostly ticks with random traffic.
    task automatic random_timer_run(input int unsigned len);
        logic [7:0]  ctrl;
        int unsigned pick;
        ctrl = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            ctrl[CTRL_ENABLE_BIT] = 1'b1;
        if ($urandom_range(0, 3) != 0)
            ctrl[2:0] = 3'($urandom_range(0, 2));
        send_item(OP_WRITE, REG_CONTROL, ctrl);
        send_item(OP_WRITE, REG_COUNT_LOW, count_near_top());
        send_item(OP_WRITE, REG_COUNT_HIGH, count_near_top());
        repeat (len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_item(OP_TICK, 2'($urandom), 8'($urandom));
            else if (pick < 82)
                send_item(OP_READ, 2'($urandom), 8'($urandom));
            else if (pick < 93)
                send_item(OP_WRITE, 2'($urandom), 8'($urandom));
            else
                send_item(OP_UNUSED, 2'($urandom), 8'($urandom));
        end
        send_item(OP_READ, REG_FLAG, 8'($urandom));
    endtask

    // Register values right after reset.
    task automatic test_reset_values();
        send_item(OP_READ, REG_CONTROL, 8'h00);
        send_item(OP_READ, REG_COUNT_LOW, 8'hFF);
        send_item(OP_READ, REG_COUNT_HIGH, 8'h00);
        send_item(OP_READ, REG_FLAG, 8'hFF);
    endtask

    // The unused operation must leave every register alone.
    task automatic test_unused_op();
        send_item(OP_UNUSED, REG_FLAG, 8'hFF);
        send_item(OP_UNUSED, REG_CONTROL, 8'h00);
    endtask

    // 8-bit wrap with the reset setting, then a flag write that only uses bit 0.
    task automatic test_overflow_8bit();
        send_item(OP_WRITE, REG_COUNT_LOW, 8'hFE);
        send_item(OP_TICK, REG_CONTROL, 8'h00);
        send_item(OP_TICK, REG_CONTROL, 8'h00);
        send_item(OP_READ, REG_FLAG, 8'h00);
        send_item(OP_WRITE, REG_FLAG, 8'hFE);
        send_item(OP_READ, REG_FLAG, 8'h00);
    endtask

    // 16-bit wrap from 0xFFFF.
    task automatic test_overflow_16bit();
        send_item(OP_WRITE, REG_CONTROL, CTRL_EN | CTRL_BYPASS);
        send_item(OP_WRITE, REG_COUNT_HIGH, 8'hFF);
        send_item(OP_WRITE, REG_COUNT_LOW, 8'hFF);
        send_item(OP_TICK, REG_COUNT_HIGH, 8'hFF);
        send_item(OP_READ, REG_COUNT_HIGH, 8'h00);
    endtask

    // A tick with the timer disabled changes nothing.
    task automatic test_disabled_tick();
        send_item(OP_WRITE, REG_CONTROL, 8'h00);
        send_item(OP_TICK, REG_COUNT_LOW, 8'h00);
        send_item(OP_READ, REG_COUNT_LOW, 8'h00);
    endtask

    // Largest ratio partly counted, then lowered to the smallest one.
    task automatic test_ratio_change();
        send_item(OP_WRITE, REG_CONTROL, CTRL_EN | CTRL_8BIT | PS_DIV_256);
        send_item(OP_TICK, REG_CONTROL, 8'h00);
        send_item(OP_TICK, REG_CONTROL, 8'h00);
        send_item(OP_WRITE, REG_CONTROL, CTRL_EN | CTRL_8BIT | PS_DIV_2);
        send_item(OP_TICK, REG_CONTROL, 8'h00);
        send_item(OP_READ, REG_COUNT_LOW, 8'h00);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_backpressure();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        long_hold     = 60;
        random_timer_run(30);
    endtask

    // Random timer runs with idling on both sides.
    task automatic test_random_traffic();
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        while (items_sent < 1050)
            random_timer_run($urandom_range(10, 60));
    endtask

    // Closing stretch at full rate with no idling.
    task automatic test_full_rate();
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        while (items_sent < 1200)
            random_timer_run($urandom_range(10, 60));
    endtask

    // Test sequence and end of run.
    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        mismatch_count = 0;
        items_sent     = 0;
        sender_idle    = 1'b0;
        receiver_idle  = 1'b0;
        long_hold      = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_unused_op();
        test_overflow_8bit();
        test_overflow_16bit();
        test_disabled_tick();
        test_ratio_change();
        test_backpressure();
        test_random_traffic();
        test_full_rate();

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
